// ===== rtl/core/ctt_pkg.sv =====
package ctt_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int FIELD_BITS  = 24;
   localparam int EXT_BITS    = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [OFFSET_BITS-1:0] pos_type;
   typedef logic [FIELD_BITS-1:0]  field_type;
   typedef logic [PTR_BITS-1:0]    ptr_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   localparam pos_type   POS_MAX   = '1;
   localparam field_type FIELD_MAX = '1;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'h0a;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_COMMA     = 8'h2c;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_UNDERLINE = 8'h5f;
   localparam logic [7:0] CH_MINUS     = 8'h2d;
   localparam logic [7:0] CH_PLUS      = 8'h2b;
   localparam logic [7:0] CH_DOT       = 8'h2e;
   localparam logic [7:0] CH_COLON     = 8'h3a;
   localparam logic [7:0] CH_EQUAL     = 8'h3d;
   localparam logic [7:0] CH_LBRACE    = 8'h7b;
   localparam logic [7:0] CH_RBRACE    = 8'h7d;
   localparam logic [7:0] CH_LBRACKET  = 8'h5b;
   localparam logic [7:0] CH_RBRACKET  = 8'h5d;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_STAR      = 8'h2a;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_Z   = 8'h7a;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_Z   = 8'h5a;
   localparam logic [7:0] CH_DIGIT_0   = 8'h30;
   localparam logic [7:0] CH_DIGIT_9   = 8'h39;

   typedef enum logic [3:0] {
      CAT_ASSIGN     = 4'd0,
      CAT_LBRACE     = 4'd1,
      CAT_RBRACE     = 4'd2,
      CAT_LBRACKET   = 4'd3,
      CAT_RBRACKET   = 4'd4,
      CAT_DOLLAR     = 4'd5,
      CAT_ID         = 4'd6,
      CAT_STRING     = 4'd7,
      CAT_EOF        = 4'd8,
      CAT_UNEXPECTED = 4'd9
   } category_type;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_ID,
      MODE_DQ,
      MODE_SQ,
      MODE_DQ_ESC,
      MODE_SQ_ESC,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BLOCK_STAR,
      MODE_ERROR
   } mode_type;

   typedef struct packed {
      category_type category;
      field_type    start_offset;
      field_type    token_length;
      logic         last_of_run;
   } token_type;

   typedef struct packed {
      logic         emit;
      category_type category;
      logic         len_one;
      logic         take_start;
      mode_type     mode;
   } idle_type;

   function automatic pos_type sat_inc(pos_type v);
      return (v == POS_MAX) ? v : pos_type'(v + 1'b1);
   endfunction

   function automatic pos_type span(pos_type from, pos_type to);
      return (to > from) ? pos_type'(to - from) : '0;
   endfunction

   function automatic field_type clip(pos_type v);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(v);
      return (ext > EXT_BITS'(FIELD_MAX)) ? FIELD_MAX : ext[FIELD_BITS-1:0];
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || c == CH_UNDERLINE ||
             c == CH_MINUS || c == CH_PLUS || c == CH_DOT;
   endfunction

   function automatic idle_type lex_idle(logic [7:0] c, logic skip);
      idle_type r;
      r = '{emit: 1'b0, category: CAT_UNEXPECTED, len_one: 1'b1, take_start: 1'b0,
            mode: MODE_IDLE};
      if (skip && (c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB || c == CH_COMMA)) begin
         r.emit = 1'b0;
      end else if (skip && c == CH_SLASH) begin
         r.take_start = 1'b1;
         r.mode       = MODE_SLASH;
      end else if (c == CH_COLON || c == CH_EQUAL) begin
         r.emit     = 1'b1;
         r.category = CAT_ASSIGN;
      end else if (c == CH_LBRACE) begin
         r.emit     = 1'b1;
         r.category = CAT_LBRACE;
      end else if (c == CH_RBRACE) begin
         r.emit     = 1'b1;
         r.category = CAT_RBRACE;
      end else if (c == CH_LBRACKET) begin
         r.emit     = 1'b1;
         r.category = CAT_LBRACKET;
      end else if (c == CH_RBRACKET) begin
         r.emit     = 1'b1;
         r.category = CAT_RBRACKET;
      end else if (c == CH_DOLLAR) begin
         r.emit     = 1'b1;
         r.category = CAT_DOLLAR;
      end else if (c == CH_DQUOTE) begin
         r.take_start = 1'b1;
         r.mode       = MODE_DQ;
      end else if (c == CH_SQUOTE) begin
         r.take_start = 1'b1;
         r.mode       = MODE_SQ;
      end else if (is_word(c)) begin
         r.take_start = 1'b1;
         r.mode       = MODE_ID;
      end else begin
         r.emit     = 1'b1;
         r.category = CAT_UNEXPECTED;
         r.len_one  = 1'b0;
         r.mode     = MODE_ERROR;
      end
      return r;
   endfunction

   function automatic token_type make_token(category_type cat, pos_type start, pos_type len,
                                            logic last);
      token_type t;
      t.category     = cat;
      t.start_offset = clip(start);
      t.token_length = clip(len);
      t.last_of_run  = last;
      return t;
   endfunction

endpackage

// ===== rtl/core/config_text_tokenizer_unit.sv =====
// streaming lexer for configuration text, one byte per request
//
// request channel (req_): req_command 0 carries req_text_byte, 1 marks end of text.
// a request is taken in every cycle in which req_valid and req_ready are both high.
// response channel (rsp_): one token per transfer with category, start offset,
// length and last_of_run, which flags the final token of a request. a request
// gives zero, one or two tokens; the end-of-text request after an error gives none.
// csr_ channel: csr_skip_blanks is written when csr_valid and csr_ready are high;
// csr_ready is always high. write it only while the unit is idle.
//
// a token enters the queue when its request is taken and leaves from its head.
// throughput: one request per cycle while req_ready is high; tokens leave one per
// cycle while rsp_ready is high, so a two-token request uses separate transfers.
// tokens wait in a four entry queue; req_ready drops while fewer than two entries
// are free, so a stalled receiver holds off new requests without losing any token.
// reset (synchronous): lexer idle, offsets zero, skip_blanks set, queue empty.
module config_text_tokenizer_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic [7:0]               req_text_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ctt_pkg::category_type    rsp_category,
   output ctt_pkg::field_type       rsp_start_offset,
   output ctt_pkg::field_type       rsp_token_length,
   output logic                     rsp_last_of_run,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_skip_blanks
);
   import ctt_pkg::*;

   logic       skip_ff;
   mode_type   mode_ff, mode_in;
   pos_type    position_ff, position_in;
   pos_type    start_ff, start_in;

   token_type  queue_ff [QUEUE_DEPTH];
   ptr_type    wr_ptr_ff, wr_ptr_in;
   ptr_type    rd_ptr_ff, rd_ptr_in;
   count_type  count_ff, count_in;

   idle_type   idle;
   logic       word;
   logic       req_take;
   logic       rsp_take;
   logic       t0_valid, t1_valid;
   token_type  t0, t1;
   pos_type    str_start;
   ptr_type    wr_next;

   assign csr_ready = 1'b1;
   assign req_ready = (count_ff <= count_type'(QUEUE_DEPTH - 2));
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && rsp_ready;

   assign idle      = lex_idle(req_text_byte, skip_ff);
   assign word      = is_word(req_text_byte);
   assign str_start = sat_inc(start_ff);

   // next state
   always_comb begin
      mode_in     = mode_ff;
      start_in    = start_ff;
      position_in = sat_inc(position_ff);
      if (req_command == CMD_END) begin
         mode_in     = MODE_IDLE;
         start_in    = '0;
         position_in = '0;
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               mode_in = idle.mode;
               if (idle.take_start) begin
                  start_in = position_ff;
               end
            end
            MODE_ID: begin
               if (!word) begin
                  mode_in = idle.mode;
                  if (idle.take_start) begin
                     start_in = position_ff;
                  end
               end
            end
            MODE_DQ: begin
               if (req_text_byte == CH_BACKSLASH) begin
                  mode_in = MODE_DQ_ESC;
               end else if (req_text_byte == CH_DQUOTE) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_SQ: begin
               if (req_text_byte == CH_BACKSLASH) begin
                  mode_in = MODE_SQ_ESC;
               end else if (req_text_byte == CH_SQUOTE) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_DQ_ESC: mode_in = MODE_DQ;
            MODE_SQ_ESC: mode_in = MODE_SQ;
            MODE_SLASH: begin
               if (req_text_byte == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (req_text_byte == CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end else begin
                  mode_in = MODE_ERROR;
               end
            end
            MODE_LINE: begin
               if (req_text_byte == CH_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_BLOCK: begin
               if (req_text_byte == CH_STAR) begin
                  mode_in = MODE_BLOCK_STAR;
               end
            end
            MODE_BLOCK_STAR: begin
               if (req_text_byte == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (req_text_byte != CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end
            end
            default: mode_in = MODE_ERROR;
         endcase
      end
   end

   // tokens of this request
   always_comb begin
      t0_valid = 1'b0;
      t1_valid = 1'b0;
      t0       = make_token(CAT_EOF, position_ff, '0, 1'b1);
      t1       = make_token(idle.category, position_ff, pos_type'(idle.len_one), 1'b1);
      if (req_command == CMD_END) begin
         case (mode_ff)
            MODE_IDLE, MODE_LINE: begin
               t0_valid = 1'b1;
            end
            MODE_ID: begin
               t0_valid = 1'b1;
               t0       = make_token(CAT_EOF, start_ff, span(start_ff, position_ff), 1'b1);
            end
            MODE_ERROR: t0_valid = 1'b0;
            default: begin
               t0_valid = 1'b1;
               t0       = make_token(CAT_UNEXPECTED, start_ff, '0, 1'b1);
            end
         endcase
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               t0_valid = idle.emit;
               t0       = make_token(idle.category, position_ff, pos_type'(idle.len_one),
                                     1'b1);
            end
            MODE_ID: begin
               t0_valid = !word;
               t1_valid = !word && idle.emit;
               t0       = make_token(CAT_ID, start_ff, span(start_ff, position_ff),
                                     !t1_valid);
            end
            MODE_DQ: begin
               t0_valid = (req_text_byte == CH_DQUOTE);
               t0       = make_token(CAT_STRING, str_start, span(str_start, position_ff),
                                     1'b1);
            end
            MODE_SQ: begin
               t0_valid = (req_text_byte == CH_SQUOTE);
               t0       = make_token(CAT_STRING, str_start, span(str_start, position_ff),
                                     1'b1);
            end
            MODE_SLASH: begin
               t0_valid = (req_text_byte != CH_SLASH) && (req_text_byte != CH_STAR);
               t0       = make_token(CAT_UNEXPECTED, start_ff, '0, 1'b1);
            end
            default: t0_valid = 1'b0;
         endcase
      end
   end

   assign wr_next = ptr_type'(wr_ptr_ff + 1'b1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = ptr_type'(wr_ptr_ff + {{(PTR_BITS-1){1'b0}}, t0_valid}
                               + {{(PTR_BITS-1){1'b0}}, t1_valid});
      end
      if (rsp_take) begin
         rd_ptr_in = ptr_type'(rd_ptr_ff + 1'b1);
      end
      count_in = count_type'(count_ff
                             + {{(COUNT_BITS-1){1'b0}}, req_take && t0_valid}
                             + {{(COUNT_BITS-1){1'b0}}, req_take && t1_valid}
                             - {{(COUNT_BITS-1){1'b0}}, rsp_take});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff     <= 1'b1;
         mode_ff     <= MODE_IDLE;
         position_ff <= '0;
         start_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            skip_ff <= csr_skip_blanks;
         end
         if (req_take) begin
            mode_ff     <= mode_in;
            position_ff <= position_in;
            start_ff    <= start_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token queue
   always_ff @(posedge clock) begin
      if (req_take && t0_valid) begin
         queue_ff[wr_ptr_ff] <= t0;
      end
      if (req_take && t1_valid) begin
         queue_ff[wr_next] <= t1;
      end
   end

   assign rsp_category     = queue_ff[rd_ptr_ff].category;
   assign rsp_start_offset = queue_ff[rd_ptr_ff].start_offset;
   assign rsp_token_length = queue_ff[rd_ptr_ff].token_length;
   assign rsp_last_of_run  = queue_ff[rd_ptr_ff].last_of_run;

endmodule

// ===== test/config_text_tokenizer_unit_tb.sv =====
module config_text_tokenizer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctt_pkg::*;

   localparam int LIMIT_CYCLES = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic         req_command = CMD_BYTE;
   logic [7:0]   req_text_byte = 8'h00;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   category_type rsp_category;
   field_type    rsp_start_offset;
   field_type    rsp_token_length;
   logic         rsp_last_of_run;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_skip_blanks = 1'b1;

   config_text_tokenizer_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_category     (rsp_category),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_skip_blanks  (csr_skip_blanks)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // lexer shadow state
   logic      skip_on = 1'b1;
   mode_type  lex_state = MODE_IDLE;
   pos_type   next_pos = '0;
   pos_type   tok_begin = '0;
   token_type run_tokens[$];
   token_type expected_tokens[$];

   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int requests_sent = 0;
   int texts_sent = 0;
   int tokens_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;

   logic [7:0] punct_chars[8] = '{CH_COLON, CH_EQUAL, CH_LBRACE, CH_RBRACE,
                                  CH_LBRACKET, CH_RBRACKET, CH_DOLLAR, CH_DOLLAR};
   logic [7:0] blank_chars[4] = '{CH_SPACE, CH_NEWLINE, CH_TAB, CH_COMMA};
   int         sender_pcts[4] = '{0, 74, 0, 29};
   int         stall_pcts[4]  = '{0, 0, 74, 29};

   function automatic pos_type bump(pos_type v);
      return (&v) ? v : pos_type'(v + 1);
   endfunction

   function automatic pos_type distance(pos_type lo, pos_type hi);
      return (hi > lo) ? pos_type'(hi - lo) : '0;
   endfunction

   function automatic field_type fit_field(pos_type v);
      if (64'(v) > 64'(FIELD_MAX)) return FIELD_MAX;
      return field_type'(v);
   endfunction

   function automatic logic word_char(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
             c == CH_UNDERLINE || c == CH_MINUS || c == CH_PLUS || c == CH_DOT;
   endfunction

   function automatic void emit_token(category_type cat, pos_type at, pos_type len);
      token_type t;
      t.category     = cat;
      t.start_offset = fit_field(at);
      t.token_length = fit_field(len);
      t.last_of_run  = 1'b0;
      run_tokens = {run_tokens, t};
   endfunction

   // byte seen between tokens
   function automatic void start_token(logic [7:0] c, pos_type at);
      if (skip_on && (c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB || c == CH_COMMA))
         return;
      if (skip_on && c == CH_SLASH) begin
         tok_begin = at;
         lex_state = MODE_SLASH;
         return;
      end
      case (c)
         CH_COLON, CH_EQUAL: emit_token(CAT_ASSIGN, at, pos_type'(1));
         CH_LBRACE:          emit_token(CAT_LBRACE, at, pos_type'(1));
         CH_RBRACE:          emit_token(CAT_RBRACE, at, pos_type'(1));
         CH_LBRACKET:        emit_token(CAT_LBRACKET, at, pos_type'(1));
         CH_RBRACKET:        emit_token(CAT_RBRACKET, at, pos_type'(1));
         CH_DOLLAR:          emit_token(CAT_DOLLAR, at, pos_type'(1));
         CH_DQUOTE: begin
            tok_begin = at;
            lex_state = MODE_DQ;
         end
         CH_SQUOTE: begin
            tok_begin = at;
            lex_state = MODE_SQ;
         end
         default: begin
            if (word_char(c)) begin
               tok_begin = at;
               lex_state = MODE_ID;
            end else begin
               emit_token(CAT_UNEXPECTED, at, '0);
               lex_state = MODE_ERROR;
            end
         end
      endcase
   endfunction

   task automatic predict_tokens(logic cmd, logic [7:0] c);
      pos_type   at;
      pos_type   body;
      at = next_pos;
      if (cmd == CMD_END) begin
         case (lex_state)
            MODE_IDLE, MODE_LINE: emit_token(CAT_EOF, at, '0);
            MODE_ID:              emit_token(CAT_EOF, tok_begin, distance(tok_begin, at));
            MODE_ERROR:           ;
            default:              emit_token(CAT_UNEXPECTED, tok_begin, '0);
         endcase
         lex_state = MODE_IDLE;
         next_pos  = '0;
         tok_begin = '0;
      end else begin
         case (lex_state)
            MODE_IDLE: start_token(c, at);
            MODE_ID: begin
               if (!word_char(c)) begin
                  emit_token(CAT_ID, tok_begin, distance(tok_begin, at));
                  lex_state = MODE_IDLE;
                  start_token(c, at);
               end
            end
            MODE_DQ, MODE_SQ: begin
               if (c == CH_BACKSLASH) begin
                  lex_state = (lex_state == MODE_DQ) ? MODE_DQ_ESC : MODE_SQ_ESC;
               end else if (c == ((lex_state == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
                  body = bump(tok_begin);
                  emit_token(CAT_STRING, body, distance(body, at));
                  lex_state = MODE_IDLE;
               end
            end
            MODE_DQ_ESC: lex_state = MODE_DQ;
            MODE_SQ_ESC: lex_state = MODE_SQ;
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  lex_state = MODE_LINE;
               end else if (c == CH_STAR) begin
                  lex_state = MODE_BLOCK;
               end else begin
                  emit_token(CAT_UNEXPECTED, tok_begin, '0);
                  lex_state = MODE_ERROR;
               end
            end
            MODE_LINE: if (c == CH_NEWLINE) lex_state = MODE_IDLE;
            MODE_BLOCK: if (c == CH_STAR) lex_state = MODE_BLOCK_STAR;
            MODE_BLOCK_STAR: begin
               if (c == CH_SLASH) lex_state = MODE_IDLE;
               else if (c != CH_STAR) lex_state = MODE_BLOCK;
            end
            default: lex_state = MODE_ERROR;
         endcase
         next_pos = bump(at);
      end
      if (run_tokens.size() != 0) begin
         run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
      end
      foreach (run_tokens[i]) expected_tokens = {expected_tokens, run_tokens[i]};
      run_tokens.delete();
   endtask

   task automatic send_request(logic cmd, logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_text_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tokens(cmd, b);
      requests_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_request(CMD_BYTE, s[i]);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_skip(logic value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_skip_blanks <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      skip_on = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_word_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
         1: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
         2: return 8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
         default: begin
            case ($urandom_range(0, 3))
               0: return CH_UNDERLINE;
               1: return CH_MINUS;
               2: return CH_PLUS;
               default: return CH_DOT;
            endcase
         end
      endcase
   endfunction

   // mostly well-formed config text, with some noise and broken endings
   task automatic send_random_text();
      int         pieces;
      int         kind;
      logic [7:0] quote;
      pieces = $urandom_range(0, 8);
      for (int i = 0; i < pieces; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            send_request(CMD_BYTE, 8'($urandom_range(0, 255)));
         end else if (kind < 30) begin
            repeat ($urandom_range(1, 6)) send_request(CMD_BYTE, random_word_char());
         end else if (kind < 45) begin
            quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            send_request(CMD_BYTE, quote);
            repeat ($urandom_range(0, 6)) begin
               if ($urandom_range(0, 4) == 0) send_request(CMD_BYTE, CH_BACKSLASH);
               send_request(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 19) != 0) send_request(CMD_BYTE, quote);
         end else if (kind < 65) begin
            send_request(CMD_BYTE, punct_chars[$urandom_range(0, 7)]);
         end else if (kind < 80) begin
            if (skip_on || $urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 3))
                  send_request(CMD_BYTE, blank_chars[$urandom_range(0, 3)]);
            else
               send_request(CMD_BYTE, punct_chars[$urandom_range(0, 7)]);
         end else if (!skip_on && $urandom_range(0, 4) != 0) begin
            send_request(CMD_BYTE, punct_chars[$urandom_range(0, 7)]);
         end else if (kind < 90) begin
            send_request(CMD_BYTE, CH_SLASH);
            send_request(CMD_BYTE, CH_SLASH);
            repeat ($urandom_range(0, 5)) send_request(CMD_BYTE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0) send_request(CMD_BYTE, CH_NEWLINE);
         end else begin
            send_request(CMD_BYTE, CH_SLASH);
            send_request(CMD_BYTE, CH_STAR);
            repeat ($urandom_range(0, 6))
               send_request(CMD_BYTE, ($urandom_range(0, 2) == 0) ? CH_STAR
                                                                  : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) != 0) begin
               send_request(CMD_BYTE, CH_STAR);
               send_request(CMD_BYTE, CH_SLASH);
            end
         end
      end
      if ($urandom_range(0, 19) == 0) send_request(CMD_BYTE, CH_SLASH);
      send_request(CMD_END, 8'($urandom_range(0, 255)));
      texts_sent++;
   endtask

   // every punctuation, escaped and empty strings, id closed by a quote, id at end
   task automatic test_tokens_and_strings();
      send_text("{}[]$=:a'\\''\"\"b");
      send_request(CMD_END, 8'h00);
      texts_sent++;
   endtask

   // block comment whose opener star does not close it, star run, line comment,
   // lone slash, bytes ignored after the error, end after an error
   task automatic test_comments_and_errors();
      send_text("/*/**///\n/x");
      send_request(CMD_BYTE, 8'hff);
      send_request(CMD_BYTE, 8'h00);
      send_request(CMD_END, 8'hff);
      texts_sent++;
   endtask

   // skip_blanks cleared inside a block comment, then an unclosed string at end
   task automatic test_skip_change_in_comment();
      send_text("/*");
      wait_for_drain();
      write_skip(1'b0);
      send_text("*/'");
      send_request(CMD_END, 8'h5a);
      wait_for_drain();
      write_skip(1'b1);
      texts_sent++;
   endtask

   task automatic test_random_texts();
      int goal;
      for (int p = 0; p < 4; p++) begin
         for (int k = 0; k < 2; k++) begin
            wait_for_drain();
            write_skip(k == 0);
            sender_idle_pct = sender_pcts[p];
            rsp_stall_pct   = stall_pcts[p];
            goal = requests_sent + 205;
            while (requests_sent < goal) send_random_text();
         end
      end
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   always @(posedge clock) begin
      token_type want;
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         tokens_checked++;
         if (expected_tokens.size() == 0) begin
            $error("token with no request behind it: category %0d start %0d length %0d",
                   rsp_category, rsp_start_offset, rsp_token_length);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_category !== want.category) begin
               $error("category: expected %0d, got %0d", want.category, rsp_category);
               mismatches++;
            end
            if (rsp_start_offset !== want.start_offset) begin
               $error("start_offset: expected %0d, got %0d", want.start_offset, rsp_start_offset);
               mismatches++;
            end
            if (rsp_token_length !== want.token_length) begin
               $error("token_length: expected %0d, got %0d", want.token_length, rsp_token_length);
               mismatches++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d", want.last_of_run, rsp_last_of_run);
               mismatches++;
            end
         end
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
                  expected_tokens.size());
         $display("** config_text_tokenizer_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_tokens_and_strings();
      test_comments_and_errors();
      test_skip_change_in_comment();
      test_random_texts();
      wait_for_drain();
      repeat (8) @(negedge clock);
      $display("covered %0d texts, %0d requests and %0d tokens checked", texts_sent,
               requests_sent, tokens_checked);
      $display("with skip_blanks on and off under four pacing modes, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("** config_text_tokenizer_unit: PASSED **");
      end else begin
         $display("** config_text_tokenizer_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== config_text_tokenizer_unit.f =====
rtl/core/ctt_pkg.sv
rtl/core/config_text_tokenizer_unit.sv
test/config_text_tokenizer_unit_tb.sv
